// ===== hw/rtl/psue_pkg.sv =====
// shared types and constants for the particle swarm update engine
package psue_pkg;

  // opcodes of an input beat
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_SCORE  = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // kinds of a result beat
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_MOVED = 2'd1;
  localparam logic [1:0] KIND_BEST  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_INERTIA   = 3'd1;
  localparam logic [2:0] REG_COGNITIVE = 3'd2;
  localparam logic [2:0] REG_SOCIAL    = 3'd3;
  localparam logic [2:0] REG_STEP      = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         particle;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    logic signed [31:0] score;
    logic [15:0]        rand_cog;
    logic [15:0]        rand_soc;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] best_score;
  } out_beat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_STEP,
    ST_WRITE,
    ST_SWEEP,
    ST_SWEEP_CMP,
    ST_OUT
  } state_t;

  // lane control from the sequencer
  typedef struct packed {
    logic mul1;   // form cognitive/social/inertia products
    logic sum;    // add the velocity terms
    logic step;   // scale velocity and add to position
  } lane_ctl_t;

endpackage

// ===== hw/rtl/psue_ram.sv =====
// generic single-port ram with registered read
module psue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/psue_lane.sv =====
// one coordinate lane: velocity and position update in stages
module psue_lane #(
  parameter int CW = 32
) (
  input  logic                    clk,
  input  psue_pkg::lane_ctl_t     ctl,
  input  logic [CW-1:0]           pos,
  input  logic [CW-1:0]           vel,
  input  logic [CW-1:0]           pbest,
  input  logic [CW-1:0]           gbest,
  input  logic [31:0]             fc,
  input  logic [31:0]             fs,
  input  logic [15:0]             inertia,
  input  logic [15:0]             step_scale,
  output logic [CW-1:0]           new_pos,
  output logic [CW-1:0]           new_vel
);

  localparam int PW = CW + 33;

  logic signed [PW-1:0] cog_r, soc_r, inr_r, stp_r;
  logic [CW-1:0]        vel_r, pos_r;
  logic signed [CW-1:0] dcog, dsoc;

  assign dcog = $signed(pbest - pos);
  assign dsoc = $signed(gbest - pos);

  // signed products; arithmetic shift gives the floor
  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      cog_r <= PW'(dcog) * $signed({1'b0, fc});
      soc_r <= PW'(dsoc) * $signed({1'b0, fs});
      inr_r <= PW'($signed(vel)) * $signed({17'd0, inertia});
      pos_r <= pos;
    end
    if (ctl.sum) begin
      vel_r <= CW'(inr_r >>> 14) + CW'(cog_r >>> 30) + CW'(soc_r >>> 30);
    end
    if (ctl.step) begin
      stp_r <= PW'($signed(vel_r)) * $signed({17'd0, step_scale});
    end
  end

  assign new_vel = vel_r;
  assign new_pos = pos_r + CW'(stp_r >>> 14);

endmodule

// ===== hw/rtl/particle_swarm_update_engine.sv =====
// top level of the particle swarm update engine
// Input beats (in_valid/in_stall/in_data) carry one opcode each; every
// beat yields exactly one result beat on out_valid/out_stall/out_data.
// Configuration is written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write it only while the block is idle;
// the block does not enforce this; cfg_ready is always high. One item
// is worked at a time. Move runs three lanes for x, y, z (product,
// sum, step-scale product and write-back, each registered); finish
// reads each active personal-best entry in the sweep state and
// compares it in the merging stage in the next cycle. Reset clears
// the global best to zero position and most negative score and the
// registers to their defaults; particle memories are undefined until
// loaded. A result is held in an output register until the receiver
// drops out_stall; the next input beat is taken once the held result
// has been delivered or leaves in the same cycle.
module particle_swarm_update_engine #(
  parameter int NUM_PARTICLES = 64,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psue_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psue_pkg::out_beat_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = $clog2(NUM_PARTICLES);
  localparam int NW = $clog2(NUM_PARTICLES + 1);

  // registers
  logic [6:0]  active_r;
  logic [15:0] inertia_r, cogw_r, socw_r, step_r;
  psue_pkg::state_t    state_r, state_nxt;
  psue_pkg::in_beat_t  item_r;
  psue_pkg::out_beat_t out_r;
  logic                out_valid_r;
  logic [3*CW-1:0]     gpos_r;
  logic [31:0]         gval_r;
  logic [NW-1:0]       idx_r;
  logic [31:0]         fc_r, fs_r;

  logic accept_in;
  logic in_range;
  logic [AW-1:0] addr;
  logic [NW-1:0] sweep_n;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != psue_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept_in = in_valid && !in_stall;
  assign in_range  = ({26'd0, item_r.particle} < 32'(NUM_PARTICLES));
  assign sweep_n   = (32'(active_r) > 32'(NUM_PARTICLES)) ? NW'(NUM_PARTICLES)
                                                           : NW'(active_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 7'd64;
      inertia_r <= 16'd13107;
      cogw_r    <= 16'd13107;
      socw_r    <= 16'd16384;
      step_r    <= 16'd1638;
    end else if (cfg_valid) begin
      case (cfg_index)
        psue_pkg::REG_ACTIVE:    active_r  <= cfg_data[6:0];
        psue_pkg::REG_INERTIA:   inertia_r <= cfg_data[15:0];
        psue_pkg::REG_COGNITIVE: cogw_r    <= cfg_data[15:0];
        psue_pkg::REG_SOCIAL:    socw_r    <= cfg_data[15:0];
        psue_pkg::REG_STEP:      step_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // particle memories
  logic            we_pos, we_vel, we_pb, we_pbs;
  logic [3*CW-1:0] pos_rd, vel_rd, pb_rd, pos_wd, vel_wd, pb_wd;
  logic [31:0]     pbs_rd;
  logic [3*CW-1:0] load_c;

  assign load_c = {CW'($signed(item_r.load_z)), CW'($signed(item_r.load_y)),
                   CW'($signed(item_r.load_x))};
  assign addr = (state_r == psue_pkg::ST_SWEEP) ? idx_r[AW-1:0] : AW'(item_r.particle);

  psue_ram #(.WIDTH(3*CW), .DEPTH(NUM_PARTICLES)) u_pos (
    .clk(clk), .we(we_pos), .addr(addr), .wdata(pos_wd), .rdata(pos_rd));
  psue_ram #(.WIDTH(3*CW), .DEPTH(NUM_PARTICLES)) u_vel (
    .clk(clk), .we(we_vel), .addr(addr), .wdata(vel_wd), .rdata(vel_rd));
  psue_ram #(.WIDTH(3*CW), .DEPTH(NUM_PARTICLES)) u_pb (
    .clk(clk), .we(we_pb), .addr(addr), .wdata(pb_wd), .rdata(pb_rd));
  psue_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_pbs (
    .clk(clk), .we(we_pbs), .addr(addr), .wdata(item_r.score), .rdata(pbs_rd));

  // three coordinate lanes
  psue_pkg::lane_ctl_t ctl;
  logic [3*CW-1:0] lane_pos, lane_vel;

  for (genvar d = 0; d < 3; d++) begin : g_lane
    psue_lane #(.CW(CW)) u_lane (
      .clk(clk), .ctl(ctl),
      .pos(pos_rd[d*CW +: CW]), .vel(vel_rd[d*CW +: CW]),
      .pbest(pb_rd[d*CW +: CW]), .gbest(gpos_r[d*CW +: CW]),
      .fc(fc_r), .fs(fs_r), .inertia(inertia_r), .step_scale(step_r),
      .new_pos(lane_pos[d*CW +: CW]), .new_vel(lane_vel[d*CW +: CW]));
  end

  // signed score compare
  function automatic logic greater(input logic [31:0] a, input logic [31:0] b);
    greater = $signed(a) > $signed(b);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psue_pkg::ST_IDLE: if (accept_in) begin
        state_nxt = (in_data.opcode == psue_pkg::OP_FINISH) ? psue_pkg::ST_SWEEP
                                                            : psue_pkg::ST_READ;
      end
      psue_pkg::ST_READ: begin
        if (!in_range) state_nxt = psue_pkg::ST_OUT;
        else if (item_r.opcode == psue_pkg::OP_MOVE) state_nxt = psue_pkg::ST_MUL1;
        else state_nxt = psue_pkg::ST_WRITE;
      end
      psue_pkg::ST_MUL1:  state_nxt = psue_pkg::ST_MUL2;
      psue_pkg::ST_MUL2:  state_nxt = psue_pkg::ST_SUM;
      psue_pkg::ST_SUM:   state_nxt = psue_pkg::ST_STEP;
      psue_pkg::ST_STEP:  state_nxt = psue_pkg::ST_WRITE;
      psue_pkg::ST_WRITE: state_nxt = psue_pkg::ST_OUT;
      psue_pkg::ST_SWEEP: state_nxt = (idx_r < sweep_n) ? psue_pkg::ST_SWEEP_CMP
                                                        : psue_pkg::ST_OUT;
      psue_pkg::ST_SWEEP_CMP: state_nxt = psue_pkg::ST_SWEEP;
      psue_pkg::ST_OUT: state_nxt = psue_pkg::ST_IDLE;
      default: state_nxt = psue_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl    = '0;
    we_pos = 1'b0;
    we_vel = 1'b0;
    we_pb  = 1'b0;
    we_pbs = 1'b0;
    pos_wd = load_c;
    vel_wd = '0;
    pb_wd  = load_c;
    case (state_r)
      psue_pkg::ST_MUL1: ctl.mul1 = 1'b1;
      psue_pkg::ST_SUM:  ctl.sum  = 1'b1;
      psue_pkg::ST_STEP: ctl.step = 1'b1;
      psue_pkg::ST_WRITE: begin
        case (item_r.opcode)
          psue_pkg::OP_LOAD: begin
            we_pos = 1'b1; we_vel = 1'b1; we_pb = 1'b1; we_pbs = 1'b1;
          end
          psue_pkg::OP_MOVE: begin
            we_pos = 1'b1; we_vel = 1'b1;
            pos_wd = lane_pos; vel_wd = lane_vel;
          end
          psue_pkg::OP_SCORE: begin
            pb_wd = pos_rd;
            if (greater(item_r.score, pbs_rd)) begin
              we_pb = 1'b1; we_pbs = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      item_r <= in_data;
      fc_r   <= cogw_r * in_data.rand_cog;
      fs_r   <= socw_r * in_data.rand_soc;
      idx_r  <= '0;
    end
    if (state_r == psue_pkg::ST_SWEEP_CMP) begin
      idx_r <= idx_r + NW'(1);
    end
    if (state_r == psue_pkg::ST_READ) begin
      out_r <= '0;
    end
    if (state_r == psue_pkg::ST_WRITE && item_r.opcode == psue_pkg::OP_MOVE) begin
      out_r.kind  <= psue_pkg::KIND_MOVED;
      out_r.out_x <= 32'($signed(lane_pos[0*CW +: CW]));
      out_r.out_y <= 32'($signed(lane_pos[1*CW +: CW]));
      out_r.out_z <= 32'($signed(lane_pos[2*CW +: CW]));
    end
    if (state_r == psue_pkg::ST_SWEEP && state_nxt == psue_pkg::ST_OUT) begin
      out_r.kind       <= psue_pkg::KIND_BEST;
      out_r.out_x      <= 32'($signed(gpos_r[0*CW +: CW]));
      out_r.out_y      <= 32'($signed(gpos_r[1*CW +: CW]));
      out_r.out_z      <= 32'($signed(gpos_r[2*CW +: CW]));
      out_r.best_score <= gval_r;
    end
  end

  // global best, merged from load and the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpos_r <= '0;
      gval_r <= 32'h8000_0000;
    end else if (state_r == psue_pkg::ST_WRITE && item_r.opcode == psue_pkg::OP_LOAD &&
                 greater(item_r.score, gval_r)) begin
      gpos_r <= load_c;
      gval_r <= item_r.score;
    end else if (state_r == psue_pkg::ST_SWEEP_CMP && greater(pbs_rd, gval_r)) begin
      gpos_r <= pb_rd;
      gval_r <= pbs_rd;
    end
  end

  // control state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psue_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == psue_pkg::ST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the particle swarm update engine
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_LEN = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  psue_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  psue_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = psue_pkg::REG_ACTIVE;
  logic [31:0]         cfg_data = '0;

  particle_swarm_update_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // swarm state as the block should hold it
  logic [31:0] pos_m [NP][3];
  logic [31:0] vel_m [NP][3];
  logic [31:0] pbest_m [NP][3];
  logic [31:0] pbest_score [NP];
  logic [31:0] gbest_pos [3];
  logic [31:0] gbest_score;
  logic [6:0]  active_cnt;
  logic [15:0] w_inertia, w_cog, w_soc, w_step;

  psue_pkg::out_beat_t pending_results[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_req = 1'b0;
  logic      hold_on = 1'b0;
  int        hold_cycles = 0;
  int        n_load = 0, n_move = 0, n_score = 0, n_finish = 0;

  // floor(a * f / 2^k), a signed
  function automatic logic [31:0] scale_floor(logic [31:0] a, logic [32:0] f, int k);
    logic signed [79:0] p;
    p = $signed(a) * $signed({1'b0, f});
    p = p >>> k;
    return p[31:0];
  endfunction

  function automatic logic score_above(logic [31:0] a, logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

  // advance the swarm by one beat and return the result it causes
  function automatic psue_pkg::out_beat_t swarm_update(psue_pkg::in_beat_t b);
    psue_pkg::out_beat_t r;
    logic [31:0] ld [3];
    logic [31:0] cog, soc, v, p;
    logic [32:0] fc, fs;
    int          n, i;
    r = '0;
    r.kind = psue_pkg::KIND_ACK;
    ld[0] = b.load_x; ld[1] = b.load_y; ld[2] = b.load_z;
    fc = w_cog * b.rand_cog;
    fs = w_soc * b.rand_soc;
    case (b.opcode)
      psue_pkg::OP_FINISH: begin
        n = (active_cnt > NP) ? NP : active_cnt;
        for (i = 0; i < n; i++) begin
          if (score_above(pbest_score[i], gbest_score)) begin
            gbest_score = pbest_score[i];
            gbest_pos = pbest_m[i];
          end
        end
        r.kind = psue_pkg::KIND_BEST;
        r.out_x = gbest_pos[0]; r.out_y = gbest_pos[1]; r.out_z = gbest_pos[2];
        r.best_score = gbest_score;
      end
      psue_pkg::OP_LOAD: begin
        for (i = 0; i < 3; i++) begin
          pos_m[b.particle][i] = ld[i];
          pbest_m[b.particle][i] = ld[i];
          vel_m[b.particle][i] = '0;
        end
        pbest_score[b.particle] = b.score;
        if (score_above(b.score, gbest_score)) begin
          gbest_score = b.score;
          gbest_pos = ld;
        end
      end
      psue_pkg::OP_MOVE: begin
        for (i = 0; i < 3; i++) begin
          p = pos_m[b.particle][i];
          cog = scale_floor(pbest_m[b.particle][i] - p, fc, 30);
          soc = scale_floor(gbest_pos[i] - p, fs, 30);
          v = scale_floor(vel_m[b.particle][i], {17'd0, w_inertia}, 14) + cog + soc;
          vel_m[b.particle][i] = v;
          p = p + scale_floor(v, {17'd0, w_step}, 14);
          pos_m[b.particle][i] = p;
          ld[i] = p;
        end
        r.kind = psue_pkg::KIND_MOVED;
        r.out_x = ld[0]; r.out_y = ld[1]; r.out_z = ld[2];
      end
      default: begin
        if (score_above(b.score, pbest_score[b.particle])) begin
          pbest_score[b.particle] = b.score;
          pbest_m[b.particle] = pos_m[b.particle];
        end
      end
    endcase
    return r;
  endfunction

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    psue_pkg::out_beat_t exp_r;
    if (out_valid && !out_stall && rst_n) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.kind !== exp_r.kind || out_data.out_x !== exp_r.out_x ||
            out_data.out_y !== exp_r.out_y || out_data.out_z !== exp_r.out_z ||
            out_data.best_score !== exp_r.best_score) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p got %p", results_seen,
                     exp_r, out_data);
        end
      end
    end
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // config writes; caller lowers cfg_valid after the batch
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      psue_pkg::REG_ACTIVE:    active_cnt = val[6:0];
      psue_pkg::REG_INERTIA:   w_inertia = val[15:0];
      psue_pkg::REG_COGNITIVE: w_cog = val[15:0];
      psue_pkg::REG_SOCIAL:    w_soc = val[15:0];
      psue_pkg::REG_STEP:      w_step = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [6:0] act, logic [15:0] wi, logic [15:0] wc,
                           logic [15:0] ws, logic [15:0] st);
    write_reg(psue_pkg::REG_ACTIVE, 32'(act));
    write_reg(psue_pkg::REG_INERTIA, 32'(wi));
    write_reg(psue_pkg::REG_COGNITIVE, 32'(wc));
    write_reg(psue_pkg::REG_SOCIAL, 32'(ws));
    write_reg(psue_pkg::REG_STEP, 32'(st));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one beat; expectation is the typed one if given, else predicted
  task automatic send_beat(psue_pkg::in_beat_t b, bit typed, psue_pkg::out_beat_t typed_r);
    psue_pkg::out_beat_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = swarm_update(b);
    pending_results.push_back(typed ? typed_r : r);
    case (b.opcode)
      psue_pkg::OP_LOAD:  n_load++;
      psue_pkg::OP_MOVE:  n_move++;
      psue_pkg::OP_SCORE: n_score++;
      default:            n_finish++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(8192) - 4096;
      default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
    endcase
  endfunction

  function automatic psue_pkg::in_beat_t rand_beat(logic [1:0] op);
    psue_pkg::in_beat_t b;
    b.opcode = op;
    b.particle = 6'($urandom_range(NP - 1));
    b.load_x = rand_coord();
    b.load_y = rand_coord();
    b.load_z = rand_coord();
    b.score = $urandom;
    b.rand_cog = 16'($urandom);
    b.rand_soc = 16'($urandom);
    return b;
  endfunction

  function automatic psue_pkg::in_beat_t mk(logic [1:0] op, int pt, logic [31:0] x,
      logic [31:0] y, logic [31:0] z, logic [31:0] sc, int rc, int rs);
    psue_pkg::in_beat_t b;
    b.opcode = op; b.particle = 6'(pt); b.load_x = x; b.load_y = y; b.load_z = z;
    b.score = sc; b.rand_cog = 16'(rc); b.rand_soc = 16'(rs);
    return b;
  endfunction

  function automatic psue_pkg::out_beat_t res(logic [1:0] k, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z,
                                              logic [31:0] sc);
    psue_pkg::out_beat_t r;
    r.kind = k; r.out_x = x; r.out_y = y; r.out_z = z; r.best_score = sc;
    return r;
  endfunction

  typedef struct {
    psue_pkg::in_beat_t  b;
    bit                  typed;
    psue_pkg::out_beat_t r;
  } stim_row_t;

  localparam psue_pkg::out_beat_t ACK = '{kind: psue_pkg::KIND_ACK, default: '0};

  initial begin
    stim_row_t rows [16];
    int        sends [4] = '{0, 59, 0, 29};
    int        stalls [4] = '{0, 0, 59, 29};
    int        i, ph, u;
    logic [1:0] op;

    // directed rows: empty sweep, extremes of load, tie scores, moves
    rows[0]  = '{mk(psue_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 0), 1,
                 res(psue_pkg::KIND_BEST, 0, 0, 0, 32'h8000_0000)};
    rows[1]  = '{mk(psue_pkg::OP_LOAD, 0, 32'h7fff_ffff, 32'h8000_0000, 0,
                    32'h8000_0000, 0, 0), 1, ACK};
    rows[2]  = '{mk(psue_pkg::OP_FINISH, 5, 0, 0, 0, 0, 0, 0), 1,
                 res(psue_pkg::KIND_BEST, 0, 0, 0, 32'h8000_0000)};
    rows[3]  = '{mk(psue_pkg::OP_LOAD, 1, 32'hffff_ffff, 1, 12345, 0, 0, 0), 1, ACK};
    rows[4]  = '{mk(psue_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0, 0), 1,
                 res(psue_pkg::KIND_BEST, 32'hffff_ffff, 1, 12345, 0)};
    rows[5]  = '{mk(psue_pkg::OP_LOAD, 63, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
                    32'h7fff_ffff, 16'hffff, 16'hffff), 1, ACK};
    rows[6]  = '{mk(psue_pkg::OP_FINISH, 63, 0, 0, 0, 0, 0, 0), 1,
                 res(psue_pkg::KIND_BEST, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
                     32'h7fff_ffff)};
    rows[7]  = '{mk(psue_pkg::OP_MOVE, 0, 0, 0, 0, 0, 16'hffff, 16'hffff), 0, ACK};
    rows[8]  = '{mk(psue_pkg::OP_MOVE, 1, 0, 0, 0, 0, 0, 0), 0, ACK};
    rows[9]  = '{mk(psue_pkg::OP_MOVE, 63, 0, 0, 0, 0, 16'h8000, 1), 0, ACK};
    rows[10] = '{mk(psue_pkg::OP_SCORE, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0), 1, ACK};
    rows[11] = '{mk(psue_pkg::OP_SCORE, 1, 0, 0, 0, 32'h8000_0000, 0, 0), 1, ACK};
    rows[12] = '{mk(psue_pkg::OP_MOVE, 0, 0, 0, 0, 0, 16'hffff, 0), 0, ACK};
    rows[13] = '{mk(psue_pkg::OP_SCORE, 63, 0, 0, 0, 32'h7fff_ffff, 0, 0), 1, ACK};
    rows[14] = '{mk(psue_pkg::OP_LOAD, 2, 32'h0001_8000, 32'hfffe_8000, 32'h0000_0001, 5,
                    0, 0), 1, ACK};
    rows[15] = '{mk(psue_pkg::OP_MOVE, 2, 0, 0, 0, 0, 16'h1234, 16'hfedc), 0, ACK};

    for (i = 0; i < NP; i++) begin
      pos_m[i] = '{default: '0}; vel_m[i] = '{default: '0};
      pbest_m[i] = '{default: '0}; pbest_score[i] = '0;
    end
    gbest_pos = '{default: '0};
    gbest_score = 32'h8000_0000;
    active_cnt = 7'd64; w_inertia = 16'd13107; w_cog = 16'd13107;
    w_soc = 16'd16384; w_step = 16'd1638;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with an empty sweep so unloaded particles stay untouched
    write_all(7'd0, 16'd13107, 16'd13107, 16'd16384, 16'd1638);
    for (i = 0; i < 16; i++) send_beat(rows[i].b, rows[i].typed, rows[i].r);
    drain();

    // random phases with different weights and idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(7'd64, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        1: write_all(7'd127, 16'hffff, 16'd0, 16'd0, 16'd0);
        2: write_all(7'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: write_all(7'($urandom_range(64, 1)), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom_range(2000)));
      endcase
      send_idle_pct = sends[ph];
      recv_stall_pct = stalls[ph];
      if (ph == 0) begin
        // load the whole swarm while the receiver holds off
        hold_req = 1'b1;
        for (i = 0; i < NP; i++) begin
          psue_pkg::in_beat_t b;
          b = rand_beat(psue_pkg::OP_LOAD);
          b.particle = 6'(i);
          send_beat(b, 0, ACK);
        end
      end
      for (i = 0; i < 200; i++) begin
        u = $urandom_range(99);
        op = (u < 20) ? psue_pkg::OP_LOAD : (u < 60) ? psue_pkg::OP_MOVE :
             (u < 85) ? psue_pkg::OP_SCORE : psue_pkg::OP_FINISH;
        send_beat(rand_beat(op), 0, ACK);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d loads, %0d moves, %0d scores, %0d sweeps; %0d results checked",
             n_load, n_move, n_score, n_finish, results_seen);
    $display("weights at zero, full scale and random; active counts 0, 1, 64, 127");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/psue_pkg.sv
hw/rtl/psue_ram.sv
hw/rtl/psue_lane.sv
hw/rtl/particle_swarm_update_engine.sv
tb/tb_top.sv
